// File: sv/rufp_pkg.sv
package rufp_pkg;

    // default frame buffer size in bytes
    localparam int FRAME_BYTES_DEF = 64;

    // depth of the request queue between parser and result stage
    localparam int QUEUE_DEPTH = 2;

    // stream widths
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 160;

    // header and tail bytes
    localparam logic [7:0] HDR_B0  = 8'hFD;
    localparam logic [7:0] HDR_B1  = 8'hFC;
    localparam logic [7:0] HDR_B2  = 8'hFB;
    localparam logic [7:0] HDR_B3  = 8'hFA;
    localparam logic [7:0] TAIL_B0 = 8'h04;
    localparam logic [7:0] TAIL_B1 = 8'h03;
    localparam logic [7:0] TAIL_B2 = 8'h02;
    localparam logic [7:0] TAIL_B3 = 8'h01;

    // report command and its minimum payload
    localparam logic [15:0] CMD_REPORT     = 16'h0043;
    localparam int          REPORT_MIN_PAY = 9;

    // byte positions inside a frame
    localparam int POS_LEN_LO = 4;
    localparam int POS_LEN_HI = 5;
    localparam int POS_CMD_LO = 6;
    localparam int POS_CMD_HI = 7;
    localparam int POS_PAY    = 8;
    localparam int PAY_CAPT   = 9;   // payload bytes kept for the report
    localparam int TAIL_BYTES = 4;
    localparam int FRAME_OVH  = 8;   // bytes a frame spans beyond its length value

    typedef enum logic [2:0] {
        ST_HDR0,
        ST_HDR1,
        ST_HDR2,
        ST_HDR3,
        ST_LEN,
        ST_BODY
    } stage_t;

    typedef enum logic [1:0] {
        STAT_GOOD     = 2'd0,
        STAT_REPORT   = 2'd1,
        STAT_BAD_LEN  = 2'd2,
        STAT_BAD_TAIL = 2'd3
    } status_t;

    // one closed frame, as handed from parser to result stage
    typedef struct packed {
        status_t     status;
        logic [15:0] command;
        logic [5:0]  plen;
        logic [7:0]  tgt_state;
        logic [15:0] mov_dist;
        logic [7:0]  mov_energy;
        logic [15:0] still_dist;
        logic [7:0]  still_energy;
        logic [15:0] det_dist;
        logic [31:0] stamp;
    } event_t;

endpackage

// File: sv/rufp_front.sv
module rufp_front #(
    parameter int FRAME_BYTES = rufp_pkg::FRAME_BYTES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [rufp_pkg::IN_TDATA_W-1:0] s_tdata,   // rx_byte[7:0], timestamp_ms[39:8]
    input  logic                          q_full,
    output logic                          evt_valid,
    output rufp_pkg::event_t              evt
);
    import rufp_pkg::*;

    localparam int POS_W   = $clog2(FRAME_BYTES + 1);
    localparam int MAX_LEN = FRAME_BYTES - FRAME_OVH;

    stage_t            stage_reg, stage_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [POS_W-1:0]  len_reg;
    logic [7:0]        len_lo_reg;
    logic [7:0]        cmd_reg  [2];
    logic [7:0]        pay_reg  [PAY_CAPT];
    logic [7:0]        tail_reg [TAIL_BYTES-1];

    logic              accept;
    logic [7:0]        rx_byte;
    logic [31:0]       stamp;
    logic [15:0]       total;
    logic              len_bad;
    logic [POS_W-1:0]  pos_inc;
    logic [POS_W-1:0]  end_pos;
    logic              overrun;
    logic              at_len_hi;
    logic              at_end;
    logic              tail_ok;
    logic [POS_W-1:0]  plen_full;
    logic [15:0]       cmd_word;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign rx_byte  = s_tdata[7:0];
    assign stamp    = s_tdata[39:8];

    // frame bookkeeping
    assign total     = {rx_byte, len_lo_reg};
    assign len_bad   = (total < 16'd2) || (total > 16'(MAX_LEN));
    assign pos_inc   = pos_reg + POS_W'(1);
    assign end_pos   = len_reg + POS_W'(FRAME_OVH);
    assign overrun   = pos_reg >= POS_W'(FRAME_BYTES);
    assign at_len_hi = pos_inc == POS_W'(POS_LEN_HI + 1);
    assign at_end    = pos_inc == end_pos;
    assign tail_ok   = (tail_reg[2] == TAIL_B0) && (tail_reg[1] == TAIL_B1) &&
                       (tail_reg[0] == TAIL_B2) && (rx_byte == TAIL_B3);
    assign plen_full = len_reg - POS_W'(2);
    assign cmd_word  = {cmd_reg[1], cmd_reg[0]};

    // next-state logic
    always_comb begin
        stage_next = stage_reg;
        pos_next   = pos_reg;
        if (accept) begin
            unique case (stage_reg)
                ST_HDR0: begin
                    stage_next = (rx_byte == HDR_B0) ? ST_HDR1 : ST_HDR0;
                    pos_next   = '0;
                end
                ST_HDR1: begin
                    if (rx_byte == HDR_B1) stage_next = ST_HDR2;
                    else stage_next = (rx_byte == HDR_B0) ? ST_HDR1 : ST_HDR0;
                    pos_next = '0;
                end
                ST_HDR2: begin
                    if (rx_byte == HDR_B2) stage_next = ST_HDR3;
                    else stage_next = (rx_byte == HDR_B0) ? ST_HDR1 : ST_HDR0;
                    pos_next = '0;
                end
                ST_HDR3: begin
                    if (rx_byte == HDR_B3) begin
                        stage_next = ST_LEN;
                        pos_next   = POS_W'(POS_LEN_LO);
                    end else begin
                        stage_next = (rx_byte == HDR_B0) ? ST_HDR1 : ST_HDR0;
                        pos_next   = '0;
                    end
                end
                ST_LEN: begin
                    if (overrun) begin
                        stage_next = ST_HDR0;
                        pos_next   = '0;
                    end else if (at_len_hi && len_bad) begin
                        stage_next = ST_HDR0;
                        pos_next   = '0;
                    end else begin
                        pos_next = pos_inc;
                        if (at_len_hi) stage_next = ST_BODY;
                    end
                end
                ST_BODY: begin
                    if (overrun || at_end) begin
                        stage_next = ST_HDR0;
                        pos_next   = '0;
                    end else begin
                        pos_next = pos_inc;
                    end
                end
                default: begin
                    stage_next = ST_HDR0;
                    pos_next   = '0;
                end
            endcase
        end
    end

    // request to the result stage
    always_comb begin
        evt_valid        = 1'b0;
        evt.status       = STAT_GOOD;
        evt.command      = '0;
        evt.plen         = '0;
        evt.tgt_state    = pay_reg[0];
        evt.mov_dist     = {pay_reg[2], pay_reg[1]};
        evt.mov_energy   = pay_reg[3];
        evt.still_dist   = {pay_reg[5], pay_reg[4]};
        evt.still_energy = pay_reg[6];
        evt.det_dist     = {pay_reg[8], pay_reg[7]};
        evt.stamp        = stamp;
        if (accept && !overrun) begin
            unique case (stage_reg)
                ST_LEN: begin
                    if (at_len_hi && len_bad) begin
                        evt_valid  = 1'b1;
                        evt.status = STAT_BAD_LEN;
                    end
                end
                ST_BODY: begin
                    if (at_end) begin
                        evt_valid = 1'b1;
                        if (tail_ok) begin
                            evt.command = cmd_word;
                            evt.plen    = 6'(plen_full);
                            if (cmd_word == CMD_REPORT &&
                                plen_full >= POS_W'(REPORT_MIN_PAY))
                                evt.status = STAT_REPORT;
                            else
                                evt.status = STAT_GOOD;
                        end else begin
                            evt.status = STAT_BAD_TAIL;
                        end
                    end
                end
                default: begin
                    evt_valid = 1'b0;
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg <= ST_HDR0;
            pos_reg   <= '0;
        end else begin
            stage_reg <= stage_next;
            pos_reg   <= pos_next;
        end
    end

    // captured frame bytes: length, command, report payload, running tail
    always_ff @(posedge aclk) begin
        if (accept && !overrun) begin
            if (stage_reg == ST_LEN) begin
                if (pos_reg == POS_W'(POS_LEN_LO)) len_lo_reg <= rx_byte;
                if (pos_reg == POS_W'(POS_LEN_HI)) len_reg <= POS_W'(total);
            end
            if (stage_reg == ST_BODY) begin
                if (pos_reg == POS_W'(POS_CMD_LO)) cmd_reg[0] <= rx_byte;
                if (pos_reg == POS_W'(POS_CMD_HI)) cmd_reg[1] <= rx_byte;
                for (int i = 0; i < PAY_CAPT; i++) begin
                    if (pos_reg == POS_W'(POS_PAY + i)) pay_reg[i] <= rx_byte;
                end
                tail_reg[2] <= tail_reg[1];
                tail_reg[1] <= tail_reg[0];
                tail_reg[0] <= rx_byte;
            end
        end
    end

endmodule

// File: sv/rufp_queue.sv
module rufp_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  rufp_pkg::event_t push_evt,
    output logic             full,
    output logic             pop_valid,
    input  logic             pop,
    output rufp_pkg::event_t pop_evt
);
    import rufp_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    event_t            entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full      = count_reg == CNT_W'(QUEUE_DEPTH);
    assign pop_valid = count_reg != '0;
    assign pop_evt   = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    // pointer and fill-count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop) count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push) count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_push) entry_reg[wr_ptr_reg] <= push_evt;
    end

endmodule

// File: sv/rufp_back.sv
module rufp_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           q_valid,
    output logic                           q_pop,
    input  rufp_pkg::event_t               q_evt,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [rufp_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import rufp_pkg::*;

    logic         out_valid_reg;
    status_t      status_reg;
    logic [15:0]  command_reg;
    logic [5:0]   plen_reg;
    logic [7:0]   tgt_state_reg;
    logic [15:0]  mov_dist_reg;
    logic [7:0]   mov_energy_reg;
    logic [15:0]  still_dist_reg;
    logic [7:0]   still_energy_reg;
    logic [15:0]  det_dist_reg;
    logic [31:0]  upd_time_reg;
    logic [15:0]  good_cnt_reg, good_cnt_next;
    logic [15:0]  bad_cnt_reg, bad_cnt_next;

    // take the next request once the output slot is free or being drained
    assign q_pop = q_valid && (!out_valid_reg || m_tready);

    // counter update by status
    always_comb begin
        good_cnt_next = good_cnt_reg;
        bad_cnt_next  = bad_cnt_reg;
        unique case (q_evt.status)
            STAT_GOOD, STAT_REPORT:    good_cnt_next = good_cnt_reg + 16'd1;
            STAT_BAD_LEN, STAT_BAD_TAIL: bad_cnt_next = bad_cnt_reg + 16'd1;
            default:                   good_cnt_next = good_cnt_reg;
        endcase
    end

    // stored report, counters and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg    <= 1'b0;
            tgt_state_reg    <= '0;
            mov_dist_reg     <= '0;
            mov_energy_reg   <= '0;
            still_dist_reg   <= '0;
            still_energy_reg <= '0;
            det_dist_reg     <= '0;
            upd_time_reg     <= '0;
            good_cnt_reg     <= '0;
            bad_cnt_reg      <= '0;
        end else begin
            if (q_pop) begin
                out_valid_reg <= 1'b1;
                good_cnt_reg  <= good_cnt_next;
                bad_cnt_reg   <= bad_cnt_next;
                if (q_evt.status == STAT_REPORT) begin
                    tgt_state_reg    <= q_evt.tgt_state;
                    mov_dist_reg     <= q_evt.mov_dist;
                    mov_energy_reg   <= q_evt.mov_energy;
                    still_dist_reg   <= q_evt.still_dist;
                    still_energy_reg <= q_evt.still_energy;
                    det_dist_reg     <= q_evt.det_dist;
                    upd_time_reg     <= q_evt.stamp;
                end
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // per-frame result fields
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            status_reg  <= q_evt.status;
            command_reg <= q_evt.command;
            plen_reg    <= q_evt.plen;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {bad_cnt_reg, good_cnt_reg, upd_time_reg, det_dist_reg,
                       still_energy_reg, still_dist_reg, mov_energy_reg, mov_dist_reg,
                       tgt_state_reg, plen_reg, command_reg, status_reg};

endmodule

// File: sv/radar_uart_frame_parser.sv
// Channel | Dir | tdata fields (lowest bit up)
// s_      | in  | rx_byte[7:0], timestamp_ms[39:8]
// m_      | out | frame_status[1:0], frame_command[17:2], payload_length[23:18],
//         |     | tgt_state[31:24], move_dist[47:32], move_energy[55:48],
//         |     | still_distance_cm[71:56], still_energy[79:72],
//         |     | detect_dist[95:80], update_time_ms[127:96],
//         |     | good_frame_count[143:128], bad_frame_count[159:144]
//
// The header/length/body parser takes one byte per cycle except while the queue is full.
// A closing byte pushes a request into the queue as it is accepted; the output register
// then loads it from the queue and raises m_tvalid unless m_ is stalled.
// s_tready drops only while the two-entry request queue is full.
// Reset (aresetn low, synchronous) returns to header hunt and clears report and counters.
module radar_uart_frame_parser #(
    parameter int FRAME_BYTES = rufp_pkg::FRAME_BYTES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [rufp_pkg::IN_TDATA_W-1:0]  s_tdata,   // rx_byte, timestamp_ms
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [rufp_pkg::OUT_TDATA_W-1:0] m_tdata    // see table above
);
    import rufp_pkg::*;

    logic   evt_valid;
    event_t evt;
    logic   q_full;
    logic   q_valid;
    logic   q_pop;
    event_t q_evt;

    // byte parser
    rufp_front #(
        .FRAME_BYTES(FRAME_BYTES)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_full    (q_full),
        .evt_valid (evt_valid),
        .evt       (evt)
    );

    // request queue
    rufp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (evt_valid),
        .push_evt  (evt),
        .full      (q_full),
        .pop_valid (q_valid),
        .pop       (q_pop),
        .pop_evt   (q_evt)
    );

    // report update and result output
    rufp_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_evt    (q_evt),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// File: tb/tb_radar_uart_frame_parser.sv
module tb_radar_uart_frame_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import rufp_pkg::*;

    localparam int FRAME_BYTES  = FRAME_BYTES_DEF;
    localparam int MAX_BODY     = FRAME_BYTES - FRAME_OVH;
    localparam int RX_BYTES     = 1650;
    localparam int QUIET_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 20;

    // result fields, lowest bit first from the bottom of the struct
    typedef struct packed {
        logic [15:0] bad_cnt;
        logic [15:0] good_cnt;
        logic [31:0] upd_time;
        logic [15:0] det_dist;
        logic [7:0]  still_en;
        logic [15:0] still_dist;
        logic [7:0]  mov_en;
        logic [15:0] mov_dist;
        logic [7:0]  tgt_state;
        logic [5:0]  plen;
        logic [15:0] command;
        status_t     status;
    } frame_result_t;

    typedef struct {
        logic [7:0]  rx_byte;
        logic [31:0] stamp;
    } rx_item_t;

    // byte-level frame decoder plus queue of frame results still due
    class frame_scoreboard;
        stage_t          stage;
        int unsigned     pos;
        int unsigned     body_len;
        logic [7:0]      frame_buf [FRAME_BYTES];
        frame_result_t   held;      // stored report fields and counters
        frame_result_t   frames_due [$];
        int              errors;

        function new();
            stage    = ST_HDR0;
            pos      = 0;
            body_len = 0;
            held     = '0;
            errors   = 0;
            foreach (frame_buf[i]) frame_buf[i] = '0;
        endfunction

        function void report_mismatch(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endfunction

        function void close_frame(status_t st, logic [15:0] cmd, logic [5:0] plen);
            frame_result_t r;
            r         = held;
            r.status  = st;
            r.command = cmd;
            r.plen    = plen;
            frames_due.push_back(r);
        endfunction

        // feed one accepted byte through the decoder
        function void note_byte(logic [7:0] b, logic [31:0] now);
            logic [7:0]  want;
            logic [15:0] total;
            logic [15:0] cmd;
            int unsigned fin;
            int unsigned plen;

            // header hunt, restarting on the first header byte
            if (stage <= ST_HDR3) begin
                case (stage)
                    ST_HDR0: want = HDR_B0;
                    ST_HDR1: want = HDR_B1;
                    ST_HDR2: want = HDR_B2;
                    default: want = HDR_B3;
                endcase
                if (b == want) begin
                    if (stage == ST_HDR3) begin
                        stage = ST_LEN;
                        pos   = POS_LEN_LO;
                    end else begin
                        stage = stage_t'(stage + 1);
                    end
                end else begin
                    stage = (b == HDR_B0) ? ST_HDR1 : ST_HDR0;
                end
                return;
            end
            if (pos >= FRAME_BYTES) begin
                stage = ST_HDR0;
                return;
            end

            frame_buf[pos] = b;
            pos++;

            // length word: reject out-of-range values at once
            if (stage == ST_LEN) begin
                if (pos == POS_CMD_LO) begin
                    total = {frame_buf[POS_LEN_HI], frame_buf[POS_LEN_LO]};
                    if (total < 2 || total > MAX_BODY) begin
                        held.bad_cnt++;
                        stage = ST_HDR0;
                        close_frame(STAT_BAD_LEN, '0, '0);
                    end else begin
                        body_len = total;
                        stage    = ST_BODY;
                    end
                end
                return;
            end

            // body: command, payload, tail
            fin = body_len + FRAME_OVH;
            if (pos != fin) return;
            stage = ST_HDR0;
            if (frame_buf[fin-4] == TAIL_B0 && frame_buf[fin-3] == TAIL_B1 &&
                frame_buf[fin-2] == TAIL_B2 && frame_buf[fin-1] == TAIL_B3) begin
                cmd  = {frame_buf[POS_CMD_HI], frame_buf[POS_CMD_LO]};
                plen = body_len - 2;
                held.good_cnt++;
                if (cmd == CMD_REPORT && plen >= REPORT_MIN_PAY) begin
                    held.tgt_state  = frame_buf[POS_PAY];
                    held.mov_dist   = {frame_buf[POS_PAY+2], frame_buf[POS_PAY+1]};
                    held.mov_en     = frame_buf[POS_PAY+3];
                    held.still_dist = {frame_buf[POS_PAY+5], frame_buf[POS_PAY+4]};
                    held.still_en   = frame_buf[POS_PAY+6];
                    held.det_dist   = {frame_buf[POS_PAY+8], frame_buf[POS_PAY+7]};
                    held.upd_time   = now;
                    close_frame(STAT_REPORT, cmd, plen[5:0]);
                end else begin
                    close_frame(STAT_GOOD, cmd, plen[5:0]);
                end
            end else begin
                held.bad_cnt++;
                close_frame(STAT_BAD_TAIL, '0, '0);
            end
        endfunction

        function void cmp_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
        endfunction

        // compare one accepted result with the oldest expected frame
        function void check_result(logic [OUT_TDATA_W-1:0] data);
            frame_result_t got;
            frame_result_t want;
            got = frame_result_t'(data);
            if (frames_due.size() == 0) begin
                report_mismatch($sformatf("unexpected result %0h", data));
                return;
            end
            want = frames_due.pop_front();
            cmp_field("frame_status", got.status, want.status);
            cmp_field("frame_command", got.command, want.command);
            cmp_field("payload_length", got.plen, want.plen);
            cmp_field("tgt_state", got.tgt_state, want.tgt_state);
            cmp_field("move_dist", got.mov_dist, want.mov_dist);
            cmp_field("move_energy", got.mov_en, want.mov_en);
            cmp_field("still_distance_cm", got.still_dist, want.still_dist);
            cmp_field("still_energy", got.still_en, want.still_en);
            cmp_field("detect_dist", got.det_dist, want.det_dist);
            cmp_field("update_time_ms", got.upd_time, want.upd_time);
            cmp_field("good_frame_count", got.good_cnt, want.good_cnt);
            cmp_field("bad_frame_count", got.bad_cnt, want.bad_cnt);
        endfunction
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;     // rx_byte, timestamp_ms
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;          // status .. bad_frame_count

    frame_scoreboard sb = new();
    rx_item_t        rx_q [$];
    logic [31:0]     ms_now = '0;
    bit              calm = 1'b1;
    int              quiet_cycles = 0;
    int              stall_hold = 0;

    radar_uart_frame_parser #(
        .FRAME_BYTES(FRAME_BYTES)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // track accepted requests and results on both channels
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_byte(s_tdata[7:0], s_tdata[39:8]);
            if (m_tvalid && m_tready) sb.check_result(m_tdata);
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // receiver: held ready/stall runs; runs that start in calm phases are ready
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_hold > 0) begin
            stall_hold <= stall_hold - 1;
        end else begin
            stall_hold <= $urandom_range(0, 15);
            m_tready   <= calm ? 1'b1 : ($urandom_range(0, 2) != 0);
        end
    end

    // nothing moving for too long
    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // timestamp creeps like a ms clock, with rare jumps
    task automatic add_byte(input logic [7:0] b);
        rx_item_t it;
        if ($urandom_range(0, 63) == 0)
            ms_now = $urandom;
        else
            ms_now = ms_now + $urandom_range(0, 5);
        it.rx_byte = b;
        it.stamp   = ms_now;
        rx_q.push_back(it);
    endtask

    // fill < 0 gives random payload bytes; a frame spans len_word + 8 bytes and its
    // last four bytes are the tail, laid over the command when the length is short
    task automatic add_frame(input logic [15:0] len_word, input logic [15:0] cmd,
                             input int fill, input bit bad_tail);
        logic [7:0] tail [4];
        logic [7:0] body [$];
        int         spoil;
        int         n;
        tail = '{TAIL_B0, TAIL_B1, TAIL_B2, TAIL_B3};
        add_byte(HDR_B0);
        add_byte(HDR_B1);
        add_byte(HDR_B2);
        add_byte(HDR_B3);
        add_byte(len_word[7:0]);
        add_byte(len_word[15:8]);
        if (len_word < 2 || len_word > MAX_BODY) return;
        n = int'(len_word) + 2;
        body.push_back(cmd[7:0]);
        body.push_back(cmd[15:8]);
        for (int i = 2; i < n; i++)
            body.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
        spoil = bad_tail ? $urandom_range(0, 3) : 4;
        for (int i = 0; i < 4; i++)
            body[n - 4 + i] = (i == spoil) ? tail[i] ^ 8'($urandom_range(1, 255)) : tail[i];
        foreach (body[i]) add_byte(body[i]);
    endtask

    task automatic build_stimulus();
        int pick;
        int k;
        // directed: report extremes, short report, length limits, bad tail
        add_frame(16'd11, CMD_REPORT, 8'hFF, 1'b0);
        ms_now = 32'hFFFF_FFF0;
        add_frame(16'd11, CMD_REPORT, 8'h00, 1'b0);
        add_frame(16'd10, CMD_REPORT, -1, 1'b0);
        add_frame(16'd0, 16'h0000, -1, 1'b0);
        add_frame(16'd1, 16'h0000, -1, 1'b0);
        add_frame(16'(MAX_BODY + 1), 16'h0000, -1, 1'b0);
        add_frame(16'hFFFF, 16'h0000, -1, 1'b0);
        add_frame(16'(MAX_BODY), 16'hFFFF, -1, 1'b0);
        add_frame(16'(MAX_BODY), CMD_REPORT, -1, 1'b0);
        add_frame(16'd2, 16'h0000, -1, 1'b0);
        add_frame(16'd20, CMD_REPORT, -1, 1'b1);
        // header mismatches, including restart on a repeated first byte
        add_byte(HDR_B0);
        add_frame(16'd12, CMD_REPORT, -1, 1'b0);
        add_byte(HDR_B0);
        add_byte(HDR_B1);
        add_byte(8'h00);
        add_frame(16'd4, 16'h1234, -1, 1'b0);
        add_byte(HDR_B0);
        add_byte(HDR_B1);
        add_byte(HDR_B2);
        add_frame(16'd14, CMD_REPORT, -1, 1'b0);

        // random: mostly well-formed frames, some noise and broken frames
        while (rx_q.size() < RX_BYTES) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                k = $urandom_range(1, 6);
                repeat (k) add_byte($urandom_range(0, 3) == 0 ? HDR_B0 : 8'($urandom));
            end else if (pick < 12) begin
                // header prefix cut short
                k = $urandom_range(1, 3);
                add_byte(HDR_B0);
                if (k > 1) add_byte(HDR_B1);
                if (k > 2) add_byte(HDR_B2);
            end else if (pick < 20) begin
                k = $urandom_range(0, 2);
                add_frame(k == 0 ? 16'($urandom_range(0, 1)) :
                          k == 1 ? 16'($urandom_range(MAX_BODY + 1, 255)) :
                                   16'($urandom_range(MAX_BODY + 1, 65535)),
                          16'h0000, -1, 1'b0);
            end else begin
                add_frame($urandom_range(0, 7) == 0 ? 16'($urandom_range(2, MAX_BODY)) :
                                                      16'($urandom_range(2, 20)),
                          $urandom_range(0, 1) ? CMD_REPORT : 16'($urandom),
                          -1, $urandom_range(0, 9) == 0);
            end
        end
    endtask

    // sender: bursts with random gaps, no gaps in calm phases
    task automatic drive_bytes();
        int idx;
        int burst;
        int gap;
        idx = 0;
        while (idx < rx_q.size()) begin
            calm  = ((idx / 200) % 4) == 0;
            burst = $urandom_range(1, 48);
            while (burst > 0 && idx < rx_q.size()) begin
                s_tvalid <= 1'b1;
                s_tdata  <= {rx_q[idx].stamp, rx_q[idx].rx_byte};
                do @(posedge aclk); while (!s_tready);
                idx++;
                burst--;
            end
            gap = (calm || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b0;
    endtask

    initial begin
        build_stimulus();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        drive_bytes();
        while (sb.frames_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.frames_due.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
